// ===== hdl/mfw_pkg.sv =====
// Shared types and constants for the median filter window block.
package mfw_pkg;

  localparam int PIX_W         = 8;
  localparam int WINDOW_DEF    = 3;
  localparam int MAX_WIDTH_DEF = 1024;

  localparam int IMG_W_W   = 11;
  localparam int IMG_H_W   = 12;
  localparam int ROW_W     = 13;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;

  localparam int RESET_WIDTH  = 1024;
  localparam int RESET_HEIGHT = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  typedef logic [PIX_W-1:0] pixel_t;

  // travels with each window through the sort stages
  typedef struct packed {
    logic valid;
    logic last;
  } sort_ctrl_t;

endpackage

// ===== hdl/mfw_line_buffer.sv =====
// Line store: one bank per window row, written at the current row, read at the current column.
module mfw_line_buffer #(
  parameter int WINDOW    = mfw_pkg::WINDOW_DEF,
  parameter int MAX_WIDTH = mfw_pkg::MAX_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic                                   wr,
  input  logic [$clog2(WINDOW)-1:0]              wr_bank,
  input  logic [$clog2(MAX_WIDTH)-1:0]           addr,
  input  logic [mfw_pkg::PIX_W-1:0]              wr_data,
  output logic [WINDOW-1:0][mfw_pkg::PIX_W-1:0]  rd_data
);
  import mfw_pkg::*;

  localparam int PTR_W = $clog2(WINDOW);

  for (genvar b = 0; b < WINDOW; b++) begin : g_bank
    logic [PIX_W-1:0] mem [MAX_WIDTH];
    logic [PIX_W-1:0] rd_q;

    always_ff @(posedge clk) begin
      if (wr && wr_bank == PTR_W'(b)) begin
        mem[addr] <= wr_data;
      end
      if (en) begin
        rd_q <= mem[addr];
      end
    end

    assign rd_data[b] = rd_q;
  end

endmodule

// ===== hdl/mfw_column_cell.sv =====
// Window column cell: holds one column of the neighborhood and passes it to the next cell.
module mfw_column_cell #(
  parameter int WINDOW = mfw_pkg::WINDOW_DEF
) (
  input  logic                                   clk,
  input  logic                                   shift,
  input  logic                                   keep,
  input  logic [WINDOW-1:0][mfw_pkg::PIX_W-1:0]  col_in,
  output logic [WINDOW-1:0][mfw_pkg::PIX_W-1:0]  col_out,
  output logic [WINDOW-1:0][mfw_pkg::PIX_W-1:0]  taps
);
  import mfw_pkg::*;

  always_ff @(posedge clk) begin
    if (shift) begin
      col_out <= col_in;
    end
  end

  // column outside the image reads as zero
  assign taps = keep ? col_out : '0;

endmodule

// ===== hdl/mfw_sort_stage.sv =====
// One round of an odd-even transposition sort, registered.
module mfw_sort_stage #(
  parameter int TAPS = mfw_pkg::WINDOW_DEF * mfw_pkg::WINDOW_DEF,
  parameter int ODD  = 0
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  mfw_pkg::sort_ctrl_t                  ctrl_in,
  input  logic [TAPS-1:0][mfw_pkg::PIX_W-1:0]  data_in,
  output mfw_pkg::sort_ctrl_t                  ctrl_out,
  output logic [TAPS-1:0][mfw_pkg::PIX_W-1:0]  data_out
);
  import mfw_pkg::*;

  logic [TAPS-1:0][PIX_W-1:0] swapped;

  always_comb begin
    swapped = data_in;
    for (int i = ODD; i + 1 < TAPS; i += 2) begin
      if (data_in[i] > data_in[i+1]) begin
        swapped[i]   = data_in[i+1];
        swapped[i+1] = data_in[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else if (en) begin
      ctrl_out <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_out <= swapped;
    end
  end

endmodule

// ===== hdl/median_filter_window.sv =====
// Top level of the streaming WINDOW x WINDOW median filter.
// A result passes through the line-store read, the column cells, TAPS odd-even sort stages and
//   the 2-entry output queue; the whole pipeline stalls while the output queue is full.
// Throughput: one item per cycle unless stalled; each line-store bank reads and writes once per clock.
// Results start HALF*W + HALF items into a frame; as many further items, pixel or pad, flush its tail.
// Reset clears counters, valid bits and the output queue and sets 1024 x 1024; no memory clearing.
module median_filter_window #(
  parameter int WINDOW    = mfw_pkg::WINDOW_DEF,
  parameter int MAX_WIDTH = mfw_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [mfw_pkg::PIX_W-1:0]       s_axis_tdata,   // [7:0] pixel
  input  logic                            s_axis_tuser,   // [0] is_pad
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [mfw_pkg::PIX_W-1:0]       m_axis_tdata,   // [7:0] filtered_pixel
  output logic                            m_axis_tlast,   // last_of_frame
  input  logic                            cfg_wr_en,
  input  logic [mfw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mfw_pkg::CFG_W-1:0]       cfg_data
);
  import mfw_pkg::*;

  localparam int HALF   = WINDOW / 2;
  localparam int TAPS   = WINDOW * WINDOW;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
  localparam int LAG_W  = $clog2(HALF * MAX_WIDTH + HALF + 1);
  localparam int PTR_W  = $clog2(WINDOW);

  // configuration
  logic [IMG_W_W-1:0] image_width;
  logic [IMG_H_W-1:0] image_height;
  logic [WCNT_W-1:0]  w_eff;
  logic [IMG_H_W-1:0] h_eff;
  logic [LAG_W-1:0]   lag;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMG_W_W'(RESET_WIDTH);
      image_height <= IMG_H_W'(RESET_HEIGHT);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      w_eff = WCNT_W'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_eff = WCNT_W'(MAX_WIDTH);
    end else begin
      w_eff = WCNT_W'(image_width);
    end
  end

  assign h_eff = (image_height == '0) ? IMG_H_W'(1) : image_height;
  assign lag   = LAG_W'(HALF) * LAG_W'(w_eff) + LAG_W'(HALF);

  // position counters: input side (col, row) and output side (ocol, orow)
  logic [COL_W-1:0] col, col_next;
  logic [ROW_W-1:0] row, row_next;
  logic [LAG_W-1:0] lead, lead_next;
  logic             started, started_next;
  logic [COL_W-1:0] ocol, ocol_next;
  logic [ROW_W-1:0] orow, orow_next;
  logic [PTR_W-1:0] ptr, ptr_next;

  logic en, accept, in_frame, ignore, go_now, drop, step, wr, res, last;
  logic col_wrap, ocol_wrap;
  logic [WINDOW-1:0] row_ok, col_ok;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign in_frame  = row < ROW_W'(h_eff);
  assign ignore    = in_frame && s_axis_tuser;
  assign go_now    = started || (lead == lag);
  assign drop      = go_now && (orow >= ROW_W'(h_eff));
  assign step      = accept && !ignore && !drop;
  assign wr        = accept && in_frame && !s_axis_tuser;
  assign res       = step && go_now;
  assign col_wrap  = (WCNT_W'(col) + WCNT_W'(1)) >= w_eff;
  assign ocol_wrap = (WCNT_W'(ocol) + WCNT_W'(1)) >= w_eff;
  assign last      = (orow == ROW_W'(h_eff) - ROW_W'(1)) && ocol_wrap;

  always_comb begin
    col_next     = col;
    row_next     = row;
    lead_next    = lead;
    started_next = started;
    ocol_next    = ocol;
    orow_next    = orow;
    ptr_next     = ptr;
    if (accept && !ignore) begin
      if (drop) begin
        col_next     = '0;
        row_next     = '0;
        lead_next    = '0;
        started_next = 1'b0;
        ocol_next    = '0;
        orow_next    = '0;
      end else begin
        if (col_wrap) begin
          col_next = '0;
          row_next = row + ROW_W'(1);
          ptr_next = (ptr == PTR_W'(WINDOW - 1)) ? '0 : ptr + PTR_W'(1);
        end else begin
          col_next = col + COL_W'(1);
        end
        if (go_now) begin
          started_next = 1'b1;
          if (ocol_wrap) begin
            ocol_next = '0;
            orow_next = orow + ROW_W'(1);
          end else begin
            ocol_next = ocol + COL_W'(1);
          end
          if (last) begin
            col_next     = '0;
            row_next     = '0;
            lead_next    = '0;
            started_next = 1'b0;
            ocol_next    = '0;
            orow_next    = '0;
          end
        end else begin
          lead_next = lead + LAG_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row     <= '0;
      lead    <= '0;
      started <= 1'b0;
      ocol    <= '0;
      orow    <= '0;
      ptr     <= '0;
    end else begin
      col     <= col_next;
      row     <= row_next;
      lead    <= lead_next;
      started <= started_next;
      ocol    <= ocol_next;
      orow    <= orow_next;
      ptr     <= ptr_next;
    end
  end

  // fetched column spans rows row-j for age j; the window's center is HALF columns back
  always_comb begin
    int x;
    for (int j = 0; j < WINDOW; j++) begin
      row_ok[j] = (row >= ROW_W'(j)) && ((row - ROW_W'(j)) < ROW_W'(h_eff));
    end
    for (int c = 0; c < WINDOW; c++) begin
      x = int'(ocol) + HALF - c;
      col_ok[c] = (x >= 0) && (x < int'(w_eff));
    end
  end

  // first stage: line store read in flight
  logic              s1_shift, s1_res, s1_last;
  logic [WINDOW-1:0] s1_row_ok, s1_col_ok;
  pixel_t            s1_pixel;
  logic [PTR_W-1:0]  s1_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_shift <= 1'b0;
      s1_res   <= 1'b0;
    end else if (en) begin
      s1_shift <= step;
      s1_res   <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_last   <= last;
      s1_row_ok <= row_ok;
      s1_col_ok <= col_ok;
      s1_pixel  <= s_axis_tdata;
      s1_ptr    <= ptr;
    end
  end

  logic [WINDOW-1:0][PIX_W-1:0] lb_rd;

  mfw_line_buffer #(
    .WINDOW    (WINDOW),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buffer (
    .clk     (clk),
    .en      (en),
    .wr      (wr),
    .wr_bank (ptr),
    .addr    (col),
    .wr_data (s_axis_tdata),
    .rd_data (lb_rd)
  );

  // rotate banks into row age order; the newest row is the item itself
  logic [WINDOW-1:0][PIX_W-1:0] fcol;

  always_comb begin
    int b;
    for (int j = 0; j < WINDOW; j++) begin
      b = int'(s1_ptr) - j;
      if (b < 0) begin
        b = b + WINDOW;
      end
      if (!s1_row_ok[j]) begin
        fcol[j] = '0;
      end else if (j == 0) begin
        fcol[j] = s1_pixel;
      end else begin
        fcol[j] = lb_rd[PTR_W'(b)];
      end
    end
  end

  // second stage: window column cells
  logic              s2_res, s2_last;
  logic [WINDOW-1:0] s2_col_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_res <= 1'b0;
    end else if (en) begin
      s2_res <= s1_res;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_last   <= s1_last;
      s2_col_ok <= s1_col_ok;
    end
  end

  logic [WINDOW-1:0][PIX_W-1:0] cell_col  [WINDOW];
  logic [WINDOW-1:0][PIX_W-1:0] cell_taps [WINDOW];

  for (genvar c = 0; c < WINDOW; c++) begin : g_cell
    logic [WINDOW-1:0][PIX_W-1:0] cin;
    if (c == 0) begin : g_head
      assign cin = fcol;
    end else begin : g_body
      assign cin = cell_col[c-1];
    end

    mfw_column_cell #(
      .WINDOW (WINDOW)
    ) u_cell (
      .clk     (clk),
      .shift   (en && s1_shift),
      .keep    (s2_col_ok[c]),
      .col_in  (cin),
      .col_out (cell_col[c]),
      .taps    (cell_taps[c])
    );
  end

  // sort network
  logic [TAPS-1:0][PIX_W-1:0] sort_in;
  sort_ctrl_t                 sort_in_ctrl;
  logic [TAPS-1:0][PIX_W-1:0] sort_data [TAPS];
  sort_ctrl_t                 sort_ctrl [TAPS];

  always_comb begin
    for (int c = 0; c < WINDOW; c++) begin
      for (int j = 0; j < WINDOW; j++) begin
        sort_in[c*WINDOW + j] = cell_taps[c][j];
      end
    end
  end

  assign sort_in_ctrl = '{valid: s2_res, last: s2_last};

  for (genvar k = 0; k < TAPS; k++) begin : g_sort
    logic [TAPS-1:0][PIX_W-1:0] din;
    sort_ctrl_t                 cin;
    if (k == 0) begin : g_first
      assign din = sort_in;
      assign cin = sort_in_ctrl;
    end else begin : g_next
      assign din = sort_data[k-1];
      assign cin = sort_ctrl[k-1];
    end

    mfw_sort_stage #(
      .TAPS (TAPS),
      .ODD  (k % 2)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctrl_in  (cin),
      .data_in  (din),
      .ctrl_out (sort_ctrl[k]),
      .data_out (sort_data[k])
    );
  end

  // two-entry output queue; the pipeline moves whenever it has room
  logic [1:0] skid_cnt;
  pixel_t     skid_q0_data, skid_q1_data;
  logic       skid_q0_last, skid_q1_last;
  logic       push, pop;

  assign en    = (skid_cnt != 2'd2);
  assign push  = en && sort_ctrl[TAPS-1].valid;
  assign pop   = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_cnt <= 2'd0;
    end else if (push && !pop) begin
      skid_cnt <= skid_cnt + 2'd1;
    end else if (pop && !push) begin
      skid_cnt <= skid_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !push) begin
      skid_q0_data <= skid_q1_data;
      skid_q0_last <= skid_q1_last;
    end else if (push && (skid_cnt == 2'd0 || pop)) begin
      skid_q0_data <= sort_data[TAPS-1][TAPS/2];
      skid_q0_last <= sort_ctrl[TAPS-1].last;
    end else if (push) begin
      skid_q1_data <= sort_data[TAPS-1][TAPS/2];
      skid_q1_last <= sort_ctrl[TAPS-1].last;
    end
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = (skid_cnt != 2'd0);
  assign m_axis_tdata  = skid_q0_data;
  assign m_axis_tlast  = skid_q0_last;

  // checks
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (res && last) |=> (row == '0 && col == '0 && !started && orow == '0))
    else $error("counters not cleared after last result of frame");

  a_res_has_column: assert property (@(posedge clk) disable iff (rst)
    s1_res |-> s1_shift)
    else $error("result issued without a window column shift");

  a_full_queue_holds: assert property (@(posedge clk) disable iff (rst)
    (skid_cnt == 2'd2 && !pop) |=> (skid_cnt == 2'd2 && $stable(skid_q0_data)))
    else $error("full output queue changed without a pop");

endmodule

// ===== dv/tb.sv =====
// Testbench for median_filter_window: queued pixel frames, in-bench median predictor, scoreboard.
`timescale 1ns / 100ps

module tb;
  import mfw_pkg::*;

  localparam int HALF      = WINDOW_DEF / 2;
  localparam int TAPS      = WINDOW_DEF * WINDOW_DEF;
  localparam int RING_ROWS = WINDOW_DEF + 1;
  localparam int SETTLE    = 3 * (TAPS + 2);
  localparam int RAND_ITEMS = 750;

  typedef enum logic [1:0] {ACT_ITEM, ACT_CFG, ACT_DRAIN} act_kind_t;

  typedef struct {
    act_kind_t             kind;
    pixel_t                pixel;
    logic                  pad;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_W-1:0]      reg_data;
  } action_t;

  typedef struct {
    pixel_t value;
    logic   last;
  } median_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [PIX_W-1:0]     s_axis_tdata = '0;   // [7:0] pixel
  logic                 s_axis_tuser = 1'b0; // [0] is_pad
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [PIX_W-1:0]     m_axis_tdata;        // [7:0] filtered_pixel
  logic                 m_axis_tlast;        // last_of_frame
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  action_t pending_q[$];
  median_t median_q[$];
  int      error_count = 0;
  int      stim_items = 0;

  // predictor state
  pixel_t          line_mem [RING_ROWS*MAX_WIDTH_DEF];
  longint          col_cnt, row_cnt;
  logic [IMG_W_W-1:0] cfg_width;
  logic [IMG_H_W-1:0] cfg_height;

  // driver and receiver state
  int      gap_left, tx_burst, settle_cnt;
  int      rx_stall, rx_burst;
  median_t want;

  median_filter_window uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic pixel_t tap_at(longint y, longint x, longint w, longint h);
    if (y < 0 || y >= h || x < 0 || x >= w || x >= MAX_WIDTH_DEF) return '0;
    return line_mem[int'((y % RING_ROWS) * MAX_WIDTH_DEF + x)];
  endfunction

  // Advances the frame counters for one accepted item and queues its median, if any.
  task automatic predict_median(input pixel_t pix, input logic pad);
    longint  w, h, pos, q, total, ro, co;
    pixel_t  taps [TAPS];
    pixel_t  v;
    int      k, j, dy, dx;
    median_t m;
    w = longint'(cfg_width);
    if (w < 1) w = 1;
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    h = longint'(cfg_height);
    if (h < 1) h = 1;
    if (row_cnt < h) begin
      if (pad) return;
      if (col_cnt < MAX_WIDTH_DEF)
        line_mem[int'((row_cnt % RING_ROWS) * MAX_WIDTH_DEF + col_cnt)] = pix;
    end
    pos   = row_cnt * w + col_cnt;
    q     = pos - (HALF * w + HALF);
    total = w * h;
    if (q >= total) begin
      col_cnt = 0;
      row_cnt = 0;
      return;
    end
    col_cnt++;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (q < 0) return;
    ro = q / w;
    co = q % w;
    k  = 0;
    for (dy = -HALF; dy <= HALF; dy++) begin
      for (dx = -HALF; dx <= HALF; dx++) begin
        taps[k] = tap_at(ro + dy, co + dx, w, h);
        k++;
      end
    end
    for (k = 1; k < TAPS; k++) begin
      v = taps[k];
      j = k - 1;
      while (j >= 0 && taps[j] > v) begin
        taps[j+1] = taps[j];
        j--;
      end
      taps[j+1] = v;
    end
    m.value = taps[TAPS/2];
    m.last  = (q == total - 1);
    median_q.push_back(m);
    if (m.last) begin
      col_cnt = 0;
      row_cnt = 0;
    end
  endtask

  task automatic add_item(input pixel_t pix, input logic pad);
    action_t a;
    a.kind     = ACT_ITEM;
    a.pixel    = pix;
    a.pad      = pad;
    a.reg_idx  = '0;
    a.reg_data = '0;
    pending_q.push_back(a);
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    action_t a;
    a.kind     = ACT_CFG;
    a.pixel    = '0;
    a.pad      = 1'b0;
    a.reg_idx  = idx;
    a.reg_data = data;
    pending_q.push_back(a);
  endtask

  // sender holds off until every queued median has come back
  task automatic add_drain();
    action_t a;
    a.kind     = ACT_DRAIN;
    a.pixel    = '0;
    a.pad      = 1'b0;
    a.reg_idx  = '0;
    a.reg_data = '0;
    pending_q.push_back(a);
  endtask

  // One full frame: w*h pixels with stray pads, then the flush tail.
  task automatic add_frame(input int w, input int h);
    int     noise, i;
    bit     salt;
    pixel_t p;
    noise = $urandom_range(0, 15);
    salt  = ($urandom_range(0, 2) == 0);
    for (i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 99) < noise) add_item(pixel_t'($urandom_range(0, 255)), 1'b1);
      if (salt && $urandom_range(0, 2) != 0) p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else p = pixel_t'($urandom_range(0, 255));
      add_item(p, 1'b0);
    end
    // either kind of item flushes once the frame pixels are in
    for (i = 0; i < HALF * w + HALF; i++)
      add_item(pixel_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    repeat ($urandom_range(0, 2)) add_item(pixel_t'($urandom_range(0, 255)), 1'b1);
    stim_items += w * h + HALF * w + HALF;
  endtask

  task automatic add_phase(input logic [CFG_W-1:0] wdata, input logic [CFG_W-1:0] hdata,
                           input int frames);
    int ew, eh;
    add_cfg(REG_IMAGE_WIDTH, wdata);
    add_cfg(REG_IMAGE_HEIGHT, hdata);
    ew = int'(wdata[IMG_W_W-1:0]);
    if (ew < 1) ew = 1;
    if (ew > MAX_WIDTH_DEF) ew = MAX_WIDTH_DEF;
    eh = int'(hdata[IMG_H_W-1:0]);
    if (eh < 1) eh = 1;
    repeat (frames) add_frame(ew, eh);
    add_drain();
  endtask

  // driver: one action from the queue at a time
  always @(posedge clk) begin
    logic                 nxt_valid, nxt_user, nxt_wr;
    logic [PIX_W-1:0]     nxt_data;
    logic [CFG_IDX_W-1:0] nxt_idx;
    logic [CFG_W-1:0]     nxt_cfg;
    action_t              act;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      cfg_wr_en     <= 1'b0;
      cfg_index     <= '0;
      cfg_data      <= '0;
      gap_left      = 0;
      tx_burst      = 0;
      settle_cnt    = 0;
      col_cnt       = 0;
      row_cnt       = 0;
      cfg_width     = IMG_W_W'(RESET_WIDTH);
      cfg_height    = IMG_H_W'(RESET_HEIGHT);
    end else begin
      nxt_valid = s_axis_tvalid;
      nxt_data  = s_axis_tdata;
      nxt_user  = s_axis_tuser;
      nxt_wr    = 1'b0;
      nxt_idx   = cfg_index;
      nxt_cfg   = cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_median(s_axis_tdata, s_axis_tuser);
        nxt_valid = 1'b0;
        if (tx_burst > 0) begin
          tx_burst--;
          gap_left = 0;
        end else begin
          if ($urandom_range(0, 39) == 0) tx_burst = $urandom_range(10, 40);
          gap_left = $urandom_range(0, 14);
        end
      end
      if (!nxt_valid) begin
        if (gap_left > 0) gap_left--;
        else if (pending_q.size() > 0) begin
          act = pending_q[0];
          case (act.kind)
            ACT_ITEM: begin
              nxt_valid = 1'b1;
              nxt_data  = act.pixel;
              nxt_user  = act.pad;
              pending_q.delete(0);
            end
            ACT_CFG: begin
              nxt_wr  = 1'b1;
              nxt_idx = act.reg_idx;
              nxt_cfg = act.reg_data;
              if (act.reg_idx == REG_IMAGE_WIDTH) cfg_width = act.reg_data[IMG_W_W-1:0];
              else cfg_height = act.reg_data[IMG_H_W-1:0];
              pending_q.delete(0);
            end
            ACT_DRAIN: begin
              if (median_q.size() == 0) begin
                if (settle_cnt >= SETTLE) begin
                  settle_cnt = 0;
                  pending_q.delete(0);
                end else settle_cnt++;
              end
            end
            default: pending_q.delete(0);
          endcase
        end
      end
      s_axis_tvalid <= nxt_valid;
      s_axis_tdata  <= nxt_data;
      s_axis_tuser  <= nxt_user;
      cfg_wr_en     <= nxt_wr;
      cfg_index     <= nxt_idx;
      cfg_data      <= nxt_cfg;
    end
  end

  // monitor: random back-pressure, compare against the oldest queued median
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_stall      = 0;
      rx_burst      = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (median_q.size() == 0) begin
          $error("unexpected result: filtered_pixel %0d, last_of_frame %0b",
                 m_axis_tdata, m_axis_tlast);
          error_count++;
        end else begin
          want = median_q.pop_front();
          if (m_axis_tdata !== want.value) begin
            $error("filtered_pixel: expected %0d, got %0d", want.value, m_axis_tdata);
            error_count++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last_of_frame: expected %0b, got %0b", want.last, m_axis_tlast);
            error_count++;
          end
        end
        if (rx_burst > 0) begin
          rx_burst--;
          rx_stall = 0;
        end else begin
          if ($urandom_range(0, 39) == 0) rx_burst = $urandom_range(10, 40);
          rx_stall = $urandom_range(0, 14);
        end
      end else if (rx_stall > 0) rx_stall--;
      m_axis_tready <= (rx_stall == 0);
    end
  end

  initial begin
    pixel_t           dir_pix [12];
    int               i, ew, eh;
    logic [CFG_W-1:0] wdata, hdata;
    dir_pix = '{8'hFF, 8'hFF, 8'hFF, 8'h00,
                8'hFF, 8'hFF, 8'hFF, 8'hAA,
                8'hFF, 8'h55, 8'h80, 8'h7F};

    // directed 4 x 3 frame: extremes, a pad inside the frame, pixels in the flush
    add_cfg(REG_IMAGE_WIDTH, CFG_W'(4));
    add_cfg(REG_IMAGE_HEIGHT, CFG_W'(3));
    for (i = 0; i < 12; i++) begin
      add_item(dir_pix[i], 1'b0);
      if (i == 5) add_item(8'hFF, 1'b1);
    end
    add_item(8'h00, 1'b1);
    add_item(8'h4D, 1'b0);
    add_item(8'hFF, 1'b1);
    add_item(8'hC8, 1'b0);
    add_item(8'h00, 1'b1);
    add_item(8'hFF, 1'b1);
    add_drain();

    // size extremes: width 0 clamps to 1, height 0 clamps to 1
    add_phase(CFG_W'(0), CFG_W'(40), 1);
    add_phase(CFG_W'(6), CFG_W'(0), 1);
    add_phase(CFG_W'(1), CFG_W'(1), 2);

    stim_items = 0;
    while (stim_items < RAND_ITEMS) begin
      ew = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
      eh = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      wdata = CFG_W'(ew);
      hdata = CFG_W'(eh);
      if (ew == 1 && $urandom_range(0, 1) == 1) wdata = '0;
      if (eh == 1 && $urandom_range(0, 1) == 1) hdata = '0;
      // top data bit lies beyond the width register
      if ($urandom_range(0, 4) == 0) wdata[CFG_W-1] = 1'b1;
      add_phase(wdata, hdata, $urandom_range(1, 3));
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_q.size() != 0 || s_axis_tvalid || median_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (error_count == 0 && median_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
